[sv/csld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock status LED driver package
// Word types, codes, configuration layout and blink pattern tables.
// ----------------------------------------------------------------------------
package csld_pkg;

    localparam int TIME_BITS = 16;
    localparam int CFG_W     = 16;
    localparam int COUNT_W   = CFG_W + 1;
    localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_MINUTE = 2'd1;
    localparam logic [1:0] KIND_PULSE  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] CS_INITIAL  = 3'd0;
    localparam logic [2:0] CS_SYNCED   = 3'd1;
    localparam logic [2:0] CS_PENDING  = 3'd2;
    localparam logic [2:0] CS_HEADLESS = 3'd3;
    localparam logic [2:0] CS_RUNNING  = 3'd4;

    localparam logic [1:0] RED_ERROR  = 2'd0;
    localparam logic [1:0] RED_OFF    = 2'd1;
    localparam logic [1:0] RED_SLOW   = 2'd2;
    localparam logic [1:0] RED_STEADY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_HALF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_EXP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEADY_ON    = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] clock_state;
    } item_t;

    typedef struct packed {
        logic green_led;
        logic red_led;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] short_time;
        logic [CFG_W-1:0] long_time;
        logic [CFG_W-1:0] error_half_period;
        logic [CFG_W-1:0] error_hold;
        logic [CFG_W-1:0] signal_expiry;
        logic [CFG_W-1:0] steady_on_time;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        short_time:        CFG_W'(20),
        long_time:         CFG_W'(90),
        error_half_period: CFG_W'(10),
        error_hold:        CFG_W'(80),
        signal_expiry:     CFG_W'(200),
        steady_on_time:    CFG_W'(6000)
    };

    function automatic logic [CFG_W-1:0] green_on(input logic [2:0] mode, input cfg_t cfg);
        logic [CFG_W-1:0] t;
        case (mode)
            CS_INITIAL:  t = cfg.short_time;
            CS_SYNCED:   t = cfg.long_time;
            CS_PENDING:  t = cfg.short_time;
            CS_HEADLESS: t = cfg.long_time;
            CS_RUNNING:  t = cfg.steady_on_time;
            default:     t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [CFG_W-1:0] green_off(input logic [2:0] mode, input cfg_t cfg);
        logic [CFG_W-1:0] t;
        case (mode)
            CS_INITIAL:  t = cfg.short_time;
            CS_SYNCED:   t = cfg.long_time;
            CS_PENDING:  t = cfg.long_time;
            CS_HEADLESS: t = cfg.short_time;
            CS_RUNNING:  t = '0;
            default:     t = cfg.short_time;
        endcase
        return t;
    endfunction

    function automatic logic [CFG_W-1:0] red_on(input logic [1:0] mode, input cfg_t cfg);
        logic [CFG_W-1:0] t;
        case (mode)
            RED_ERROR: t = cfg.error_half_period;
            RED_SLOW:  t = cfg.short_time;
            default:   t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [CFG_W-1:0] red_off(input logic [1:0] mode, input cfg_t cfg);
        logic [CFG_W-1:0] t;
        case (mode)
            RED_ERROR: t = cfg.error_half_period;
            RED_SLOW:  t = cfg.long_time;
            default:   t = '0;
        endcase
        return t;
    endfunction

endpackage

[sv/csld_blink.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blink phase counter step
// Computes the next phase count of one LED pattern from its on and off times.
// ----------------------------------------------------------------------------
module csld_blink (
    input  logic                          restart,
    input  logic [csld_pkg::COUNT_W-1:0]  count,
    input  logic [csld_pkg::CFG_W-1:0]    on_time,
    input  logic [csld_pkg::CFG_W-1:0]    off_time,
    output logic [csld_pkg::COUNT_W-1:0]  count_next
);
    import csld_pkg::*;

    logic [COUNT_W-1:0] period;
    logic [COUNT_W:0]   count_inc;

    assign period    = {1'b0, on_time} + {1'b0, off_time};
    assign count_inc = {1'b0, count} + {{COUNT_W{1'b0}}, 1'b1};

    always_comb
    begin
        if (restart || (count_inc >= {1'b0, period}))
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_inc[COUNT_W-1:0];
        end
    end

endmodule

[sv/clock_status_led_driver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock status LED driver
// Green and red status LEDs of a radio-synchronized clock, driven by ticks
// and receiver events.
// ----------------------------------------------------------------------------
// One word is accepted every clock cycle while the input register is free or
// advancing, and every word yields one result word. A word is held in the
// input register until the result register can take it; its state update
// and LED levels are then computed and land in the result register, which
// presents the result until it is taken. The rate of one word per cycle
// when the output is not stalled is set by the combinational counter
// update between those two registers. Configuration writes take effect for
// the next word taken into the input register.
module clock_status_led_driver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  csld_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output csld_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [csld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csld_pkg::CFG_W-1:0]      cfg_data
);
    import csld_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic    s1_valid_reg, s1_valid_next;
    item_t   s1_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    advance;
    logic    tick;

    logic [2:0]           green_mode_reg, green_mode_next;
    logic [COUNT_W-1:0]   green_count_reg, green_count_next, green_blink;
    logic [1:0]           red_mode_reg, red_mode_next;
    logic [COUNT_W-1:0]   red_count_reg, red_count_next, red_blink;
    logic [TIME_BITS-1:0] error_age_reg, error_age_next;
    logic [TIME_BITS-1:0] signal_age_reg, signal_age_next;
    logic                 error_pending_reg, error_pending_next;
    logic                 minute_ok_reg, minute_ok_next;
    logic                 signal_valid_reg, signal_valid_next;
    logic                 green_restart, red_restart;
    logic [1:0]           red_mode_tick;
    logic [CFG_W-1:0]     red_on_next;

    assign advance      = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || advance;
    assign tick         = advance && (s1_item_reg.kind == KIND_TICK);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SHORT_TIME: cfg_next.short_time        = cfg_data;
                REG_LONG_TIME:  cfg_next.long_time         = cfg_data;
                REG_ERROR_HALF: cfg_next.error_half_period = cfg_data;
                REG_ERROR_HOLD: cfg_next.error_hold        = cfg_data;
                REG_SIGNAL_EXP: cfg_next.signal_expiry     = cfg_data;
                REG_STEADY_ON:  cfg_next.steady_on_time    = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_ready)
        begin
            s1_valid_next = item_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Flag, timer and mode updates; events touch flags, and a pulse also clears the signal age.
    always_comb
    begin
        error_pending_next = error_pending_reg;
        minute_ok_next     = minute_ok_reg;
        signal_valid_next  = signal_valid_reg;
        signal_age_next    = signal_age_reg;
        error_age_next     = error_age_reg;
        green_mode_next    = green_mode_reg;
        red_mode_tick      = red_mode_reg;
        if (advance)
        begin
            case (s1_item_reg.kind)
                KIND_TICK:
                begin
                    green_mode_next = s1_item_reg.clock_state;
                    if (signal_valid_reg)
                    begin
                        if (signal_age_reg != {TIME_BITS{1'b1}})
                        begin
                            signal_age_next = signal_age_reg + 1'b1;
                        end
                        if (CMP_W'(signal_age_next) >= CMP_W'(cfg_reg.signal_expiry))
                        begin
                            signal_valid_next = 1'b0;
                            minute_ok_next    = 1'b0;
                        end
                    end
                    if (error_pending_reg)
                    begin
                        error_pending_next = 1'b0;
                        error_age_next     = '0;
                        red_mode_tick      = RED_ERROR;
                    end
                    else if (red_mode_reg == RED_ERROR)
                    begin
                        if (error_age_reg != {TIME_BITS{1'b1}})
                        begin
                            error_age_next = error_age_reg + 1'b1;
                        end
                        if (CMP_W'(error_age_next) >= CMP_W'(cfg_reg.error_hold))
                        begin
                            red_mode_tick = RED_STEADY;
                        end
                    end
                    if (red_mode_tick != RED_ERROR)
                    begin
                        if (minute_ok_next)
                        begin
                            red_mode_tick = RED_OFF;
                        end
                        else if (signal_valid_next)
                        begin
                            red_mode_tick = RED_SLOW;
                        end
                        else
                        begin
                            red_mode_tick = RED_STEADY;
                        end
                    end
                end
                KIND_MINUTE:
                begin
                    minute_ok_next = 1'b1;
                end
                KIND_PULSE:
                begin
                    signal_valid_next = 1'b1;
                    signal_age_next   = '0;
                end
                KIND_ERROR:
                begin
                    error_pending_next = 1'b1;
                    minute_ok_next     = 1'b0;
                end
                default:
                begin
                    error_pending_next = error_pending_reg;
                end
            endcase
        end
    end

    assign green_restart = (s1_item_reg.clock_state != green_mode_reg);
    assign red_restart   = (red_mode_tick != red_mode_reg);

    csld_blink u_green_blink (
        .restart    (green_restart),
        .count      (green_count_reg),
        .on_time    (green_on(green_mode_reg, cfg_reg)),
        .off_time   (green_off(green_mode_reg, cfg_reg)),
        .count_next (green_blink)
    );

    csld_blink u_red_blink (
        .restart    (red_restart),
        .count      (red_count_reg),
        .on_time    (red_on(red_mode_reg, cfg_reg)),
        .off_time   (red_off(red_mode_reg, cfg_reg)),
        .count_next (red_blink)
    );

    assign green_count_next = tick ? green_blink : green_count_reg;
    assign red_count_next   = tick ? red_blink : red_count_reg;
    assign red_mode_next    = red_mode_tick;
    assign red_on_next      = red_on(red_mode_next, cfg_reg);

    always_comb
    begin
        out_next = out_reg;
        if (advance)
        begin
            out_next.green_led = (green_count_next <
                                  {1'b0, green_on(green_mode_next, cfg_reg)});
            case (red_mode_next)
                RED_OFF:    out_next.red_led = 1'b0;
                RED_STEADY: out_next.red_led = 1'b1;
                default:    out_next.red_led = (red_count_next < {1'b0, red_on_next});
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg           <= CFG_RESET;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            green_mode_reg    <= CS_INITIAL;
            green_count_reg   <= '0;
            red_mode_reg      <= RED_STEADY;
            red_count_reg     <= '0;
            error_age_reg     <= '0;
            signal_age_reg    <= '0;
            error_pending_reg <= 1'b0;
            minute_ok_reg     <= 1'b0;
            signal_valid_reg  <= 1'b0;
        end
        else
        begin
            cfg_reg           <= cfg_next;
            s1_valid_reg      <= s1_valid_next;
            out_valid_reg     <= out_valid_next;
            green_mode_reg    <= green_mode_next;
            green_count_reg   <= green_count_next;
            red_mode_reg      <= red_mode_next;
            red_count_reg     <= red_count_next;
            error_age_reg     <= error_age_next;
            signal_age_reg    <= signal_age_next;
            error_pending_reg <= error_pending_next;
            minute_ok_reg     <= minute_ok_next;
            signal_valid_reg  <= signal_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready)
        begin
            s1_item_reg <= item;
        end
        out_reg <= out_next;
    end

`ifndef SYNTH
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("Input register lost or changed a stalled word.");

    a_slow_needs_signal: assert property (@(posedge clk) disable iff (!rst_n)
        (red_mode_reg == RED_SLOW) |-> signal_valid_reg)
        else $error("Red LED blinks slowly without a valid signal.");

    a_expiry_clears_minute: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(signal_valid_reg) |-> !minute_ok_reg)
        else $error("Signal expired but the decoded minute flag stayed set.");

    a_red_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (red_mode_reg != $past(red_mode_reg)) |-> (red_count_reg == '0))
        else $error("Red pattern did not restart on a mode change.");

    a_green_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (green_mode_reg != $past(green_mode_reg)) |-> (green_count_reg == '0))
        else $error("Green pattern did not restart on a state change.");
`endif

endmodule
